/* hdl/frm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg: shared types and opcodes for the four register alu machine
// Instruction field widths, opcode encodings and the result value width.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int CMD_W   = 3;
    localparam int REG_W   = 2;
    localparam int VALUE_W = 64;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [REG_W-1:0]   t_reg_idx;
    typedef logic [VALUE_W-1:0] t_value;

    localparam t_cmd OP_IN  = 3'd0;
    localparam t_cmd OP_MOV = 3'd1;
    localparam t_cmd OP_ADD = 3'd2;
    localparam t_cmd OP_SUB = 3'd3;
    localparam t_cmd OP_MUL = 3'd4;
    localparam t_cmd OP_DIV = 3'd5;
    localparam t_cmd OP_OUT = 3'd6;

endpackage

/* hdl/frm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_ram: generic register file memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/four_register_alu_machine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_alu_machine_unit: register machine instruction executor
// Runs load, move, add, sub, mul, div and out on a small register file;
// multiply and divide run bit-serially through shift registers.
// ----------------------------------------------------------------------------
// One instruction is taken at a time. Load, move, add, sub and an unused
// opcode pass through a register file read, and all but the unused opcode
// then write back. Out and a divide by zero pass through a result state that
// waits for the output register to drain. Multiply and divide run one bit per
// cycle through a shared shift-add / restoring-subtract datapath and then
// write back. The result register lets a new instruction be taken while the
// last result still waits downstream.
// Registers read as zero after reset through per-entry valid bits.
module four_register_alu_machine_unit #(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  frm_pkg::t_cmd     i_cmd,
    input  frm_pkg::t_reg_idx i_dest_reg,
    input  frm_pkg::t_reg_idx i_src_reg,
    input  frm_pkg::t_value   i_immediate,
    output logic              o_valid,
    input  logic              i_ready,
    output frm_pkg::t_value   o_value,
    output logic              o_div_fault
);
    import frm_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CW  = $clog2(W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0]        r_state, n_state;
    t_cmd              r_cmd;
    t_reg_idx          r_dst;
    t_reg_idx          r_src;
    logic [W-1:0]      r_imm;
    logic [W-1:0]      r_x, n_x;
    logic [W-1:0]      r_y, n_y;
    logic [W-1:0]      r_acc, n_acc;
    logic              r_neg, n_neg;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [NUM_REGS-1:0] r_valid;
    logic              r_out_valid;
    t_value            r_out_value;
    logic              r_out_fault;

    logic              accept;
    logic              dst_in_range;
    logic              src_in_range;
    logic [AW-1:0]     dst_addr;
    logic [AW-1:0]     src_addr;
    logic [W-1:0]      ram_a;
    logic [W-1:0]      ram_b;
    logic [W-1:0]      op_a;
    logic [W-1:0]      op_b;
    logic              ram_we;
    logic [W-1:0]      ram_wdata;
    logic              res_load;
    logic              res_fault;
    logic [W-1:0]      rem_sh;
    logic              rem_geq;
    logic              out_free;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign dst_addr = AW'(r_dst);
    assign src_addr = AW'(r_src);
    assign dst_in_range = (32'(r_dst) < NUM_REGS);
    assign src_in_range = (32'(r_src) < NUM_REGS);
    assign out_free = !r_out_valid || i_ready;

    frm_ram #(
        .WIDTH (W),
        .DEPTH (NUM_REGS),
        .AW    (AW)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (dst_addr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (AW'(i_dest_reg)),
        .i_raddr_b (AW'(i_src_reg)),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // entries never written and indexes past the file read as zero
    assign op_a = (dst_in_range && r_valid[dst_addr]) ? ram_a : '0;
    assign op_b = (src_in_range && r_valid[src_addr]) ? ram_b : '0;

    // restoring divide step: remainder in r_acc, dividend/quotient in r_x
    assign rem_sh  = {r_acc[W-2:0], r_x[W-1]};
    assign rem_geq = (rem_sh >= r_y);

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        ram_we    = 1'b0;
        ram_wdata = '0;
        res_load  = 1'b0;
        res_fault = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
                n_cnt   = CW'(W - 1);
                n_acc   = '0;
                case (r_cmd)
                    OP_IN: begin
                        ram_we    = dst_in_range;
                        ram_wdata = r_imm;
                    end
                    OP_MOV: begin
                        ram_we    = dst_in_range;
                        ram_wdata = op_b;
                    end
                    OP_ADD: begin
                        ram_we    = dst_in_range;
                        ram_wdata = op_a + op_b;
                    end
                    OP_SUB: begin
                        ram_we    = dst_in_range;
                        ram_wdata = op_a - op_b;
                    end
                    OP_MUL: begin
                        n_x     = op_a;
                        n_y     = op_b;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        n_neg = op_a[W-1] ^ op_b[W-1];
                        n_x   = op_a[W-1] ? (W'(0) - op_a) : op_a;
                        n_y   = op_b[W-1] ? (W'(0) - op_b) : op_b;
                        if (op_b == '0) begin
                            n_state = S_RES;
                            n_acc   = '0;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    OP_OUT: begin
                        n_acc   = op_a;
                        n_state = S_RES;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x   = {r_x[W-2:0], 1'b0};
                n_y   = {1'b0, r_y[W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                n_acc = rem_geq ? (rem_sh - r_y) : rem_sh;
                n_x   = {r_x[W-2:0], rem_geq};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                ram_we = dst_in_range;
                if (r_cmd == OP_MUL) begin
                    ram_wdata = r_acc;
                end else begin
                    ram_wdata = r_neg ? (W'(0) - r_x) : r_x;
                end
                n_state = S_IDLE;
            end
            S_RES: begin
                res_fault = (r_cmd == OP_DIV);
                if (out_free) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[dst_addr] <= 1'b1;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_dst <= i_dest_reg;
            r_src <= i_src_reg;
            r_imm <= i_immediate[W-1:0];
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (res_load) begin
            r_out_value <= res_fault ? '0 : VALUE_W'($signed(r_acc));
            r_out_fault <= res_fault;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_div_fault = r_out_fault;

`ifndef SYNTHESIS
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted beat did not start a register read");

    a_write_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_READ || r_state == S_FIN))
        else $error("register write outside write-back");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_value == '0))
        else $error("fault result carries a nonzero value");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> out_free)
        else $error("result loaded over an undelivered beat");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for four_register_alu_machine_unit
// Feeds a short directed program and then a long random instruction stream.
// An in-bench model of the four-register file predicts every out and every
// divide-by-zero fault. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    import frm_pkg::*;

    localparam t_cmd     OP_UNUSED = 3'd7;
    localparam t_reg_idx REG_A     = 2'd0;
    localparam t_reg_idx REG_B     = 2'd1;
    localparam t_reg_idx REG_C     = 2'd2;
    localparam t_reg_idx REG_D     = 2'd3;

    localparam t_value VAL_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam t_value VAL_MIN  = 64'h8000_0000_0000_0000;
    localparam t_value VAL_NEG1 = 64'hffff_ffff_ffff_ffff;

    localparam int RANDOM_INSTRS = 1850;
    localparam int TAIL_INSTRS   = 250;   // no idling while this many remain

    typedef struct packed {
        t_cmd     cmd;
        t_reg_idx dst;
        t_reg_idx src;
        t_value   imm;
    } t_instr;

    typedef struct packed {
        t_value value;
        logic   fault;
    } t_machine_out;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_valid     = 1'b0;
    logic     o_ready;
    t_cmd     i_cmd       = OP_IN;
    t_reg_idx i_dest_reg  = REG_A;
    t_reg_idx i_src_reg   = REG_A;
    t_value   i_immediate = '0;
    logic     o_valid;
    logic     i_ready     = 1'b0;
    t_value   o_value;
    logic     o_div_fault;

    four_register_alu_machine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_dest_reg  (i_dest_reg),
        .i_src_reg   (i_src_reg),
        .i_immediate (i_immediate),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_div_fault (o_div_fault)
    );

    t_instr       program_q[$];
    t_machine_out expected_outs[$];
    t_value       regfile[4];

    int  fail_count   = 0;
    int  outs_checked = 0;
    int  faults_seen  = 0;
    int  op_count[8];
    int  send_gap     = 0;
    int  stall_left   = 0;
    bit  send_idle_en = 1'b1;
    bit  recv_idle_en = 1'b1;
    bit  tail_phase   = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // signed divide on magnitudes so the most negative over -1 wraps cleanly
    function automatic t_value trunc_div(t_value n, t_value d);
        t_value un;
        t_value ud;
        t_value q;
        un = n[63] ? -n : n;
        ud = d[63] ? -d : d;
        q  = un / ud;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic void execute_instr(t_instr ins);
        t_value a;
        t_value b;
        a = regfile[ins.dst];
        b = regfile[ins.src];
        op_count[ins.cmd]++;
        case (ins.cmd)
            OP_IN:  regfile[ins.dst] = ins.imm;
            OP_MOV: regfile[ins.dst] = b;
            OP_ADD: regfile[ins.dst] = a + b;
            OP_SUB: regfile[ins.dst] = a - b;
            OP_MUL: regfile[ins.dst] = a * b;
            OP_DIV: begin
                if (b == '0) begin
                    expected_outs.push_back('{value: '0, fault: 1'b1});
                end else begin
                    regfile[ins.dst] = trunc_div(a, b);
                end
            end
            OP_OUT: expected_outs.push_back('{value: a, fault: 1'b0});
            default: ;
        endcase
    endfunction

    function automatic void add_instr(t_cmd c, t_reg_idx d, t_reg_idx s, t_value imm);
        program_q.push_back('{cmd: c, dst: d, src: s, imm: imm});
    endfunction

    function automatic t_value rand_imm();
        case ($urandom_range(0, 5))
            0, 1: return {$urandom, $urandom};
            2:    return t_value'($urandom_range(0, 40)) - 64'd20;
            3:    return t_value'($urandom_range(0, 7));
            4: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return VAL_NEG1;
                    3: return 64'd1;
                    default: return '0;
                endcase
            end
            default: return t_value'($signed($urandom));
        endcase
    endfunction

    function automatic void add_random_instr();
        int       pick;
        t_cmd     c;
        pick = $urandom_range(0, 99);
        if (pick < 20)      c = OP_IN;
        else if (pick < 28) c = OP_MOV;
        else if (pick < 37) c = OP_ADD;
        else if (pick < 46) c = OP_SUB;
        else if (pick < 56) c = OP_MUL;
        else if (pick < 70) c = OP_DIV;
        else if (pick < 96) c = OP_OUT;
        else                c = OP_UNUSED;
        add_instr(c, t_reg_idx'($urandom_range(0, 3)), t_reg_idx'($urandom_range(0, 3)),
                  rand_imm());
    endfunction

    // driver: presents one beat at a time, holds it until accepted
    always @(posedge i_clk) begin
        logic   nxt_valid;
        t_instr nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                execute_instr('{cmd: i_cmd, dst: i_dest_reg, src: i_src_reg,
                                imm: i_immediate});
                nxt_valid = 1'b0;
                if ($urandom_range(0, 119) == 0) send_idle_en = ~send_idle_en;
            end
            tail_phase <= (program_q.size() < TAIL_INSTRS);
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (program_q.size() > 0) begin
                    if (!tail_phase && send_idle_en && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(0, 8);
                    end else begin
                        nxt = program_q.pop_front();
                        nxt_valid = 1'b1;
                        i_cmd       <= nxt.cmd;
                        i_dest_reg  <= nxt.dst;
                        i_src_reg   <= nxt.src;
                        i_immediate <= nxt.imm;
                    end
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // result side back-pressure, independent of o_valid
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!tail_phase && recv_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 299) == 0) recv_idle_en = ~recv_idle_en;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_machine_out exp_out;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outs.size() == 0) begin
                $error("unexpected result beat: value %0h div_fault %0b", o_value, o_div_fault);
                fail_count++;
            end else begin
                exp_out = expected_outs.pop_front();
                outs_checked++;
                if (exp_out.fault) faults_seen++;
                if (o_value !== exp_out.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(exp_out.value), $signed(o_value));
                    fail_count++;
                end
                if (o_div_fault !== exp_out.fault) begin
                    $error("div_fault: expected %0b, got %0b", exp_out.fault, o_div_fault);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int real_instrs;
        foreach (regfile[k]) regfile[k] = '0;
        foreach (op_count[k]) op_count[k] = 0;

        // directed program: extremes, wraparound, every opcode, divide corners
        add_instr(OP_OUT, REG_A, REG_B, '0);            // reset value
        add_instr(OP_IN,  REG_A, REG_D, VAL_MAX);
        add_instr(OP_IN,  REG_B, REG_C, VAL_MIN);
        add_instr(OP_IN,  REG_C, REG_B, VAL_NEG1);
        add_instr(OP_IN,  REG_D, REG_A, '0);
        add_instr(OP_OUT, REG_A, REG_A, VAL_NEG1);
        add_instr(OP_OUT, REG_B, REG_A, '0);
        add_instr(OP_ADD, REG_A, REG_A, '0);            // max + max wraps
        add_instr(OP_SUB, REG_D, REG_B, '0);            // 0 - min wraps to min
        add_instr(OP_MUL, REG_C, REG_C, '0);
        add_instr(OP_IN,  REG_C, REG_A, VAL_NEG1);
        add_instr(OP_DIV, REG_B, REG_C, '0);            // min / -1 wraps
        add_instr(OP_IN,  REG_D, REG_A, '0);
        add_instr(OP_DIV, REG_A, REG_D, '0);            // divide by zero
        add_instr(OP_MOV, REG_D, REG_B, '0);
        add_instr(OP_UNUSED, REG_A, REG_B, VAL_MAX);
        add_instr(OP_IN,  REG_A, REG_B, -64'sd7);
        add_instr(OP_IN,  REG_C, REG_D, 64'd2);
        add_instr(OP_DIV, REG_A, REG_C, '0);            // truncates toward zero
        add_instr(OP_MUL, REG_B, REG_C, '0);
        add_instr(OP_OUT, REG_A, REG_D, '0);
        add_instr(OP_OUT, REG_B, REG_C, '0);
        add_instr(OP_OUT, REG_C, REG_B, '0);
        add_instr(OP_OUT, REG_D, REG_A, '0);

        real_instrs = 0;
        while (real_instrs < RANDOM_INSTRS) begin
            add_random_instr();
            if (program_q[$].cmd != OP_UNUSED) real_instrs++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (program_q.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_outs.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("ran in/mov/add/sub/mul/div/out/unused = %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 op_count[OP_IN], op_count[OP_MOV], op_count[OP_ADD], op_count[OP_SUB],
                 op_count[OP_MUL], op_count[OP_DIV], op_count[OP_OUT], op_count[OP_UNUSED]);
        $display("checked %0d result beats, %0d of them divide-by-zero faults",
                 outs_checked, faults_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
